/* rtl/core/tribc_pkg.sv */
// Package of shared types and constants for the barycentric block.
package tribc_pkg;

    localparam int COORD_W              = 16;
    localparam int WEIGHT_W             = 24;
    localparam int THRESH_W             = 16;
    localparam int DEF_COORD_FRAC_BITS  = 4;
    localparam int DEF_WEIGHT_FRAC_BITS = 16;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd3;

    // Differences are 17 bits, products 34, cross terms 35.
    localparam int DIFF_W  = COORD_W + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int MAG_W   = CROSS_W - 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] vert0_x;
        logic signed [COORD_W-1:0] vert0_y;
        logic signed [COORD_W-1:0] vert1_x;
        logic signed [COORD_W-1:0] vert1_y;
        logic signed [COORD_W-1:0] vert2_x;
        logic signed [COORD_W-1:0] vert2_y;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } tri_word_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight_first;
        logic signed [WEIGHT_W-1:0] weight_second;
        logic signed [WEIGHT_W-1:0] weight_third;
        logic                       degenerate;
    } weight_word_t;

    // Cross products handed from the front end to the divider.
    typedef struct packed {
        logic                      valid;
        logic                      degenerate;
        logic [MAG_W-1:0]          cz_mag;
        logic [MAG_W-1:0]          cx_mag;
        logic [MAG_W-1:0]          cy_mag;
        logic                      u_neg;
        logic                      v_neg;
    } cross_word_t;

endpackage

/* rtl/core/tribc_cross.sv */
// Front end: edge differences, products, cross terms and degenerate test.
module tribc_cross
    import tribc_pkg::*;
#(
    parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  tri_word_t           in_word,
    input  logic [THRESH_W-1:0] threshold,
    output cross_word_t         out_cross
);

    localparam int PROD_W = 2 * DIFF_W;

    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, rx_reg, ry_reg;
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [CROSS_W-1:0] cx, cy, cz;
    logic [MAG_W-1:0]          czm;
    logic [MAG_W+8:0]          area;
    logic [MAG_W+8:0]          limit;
    cross_word_t               out_reg;

    // Stage 1: edge vectors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d1x_reg <= DIFF_W'(in_word.vert1_x) - DIFF_W'(in_word.vert0_x);
        d1y_reg <= DIFF_W'(in_word.vert1_y) - DIFF_W'(in_word.vert0_y);
        d2x_reg <= DIFF_W'(in_word.vert2_x) - DIFF_W'(in_word.vert0_x);
        d2y_reg <= DIFF_W'(in_word.vert2_y) - DIFF_W'(in_word.vert0_y);
        rx_reg  <= DIFF_W'(in_word.vert0_x) - DIFF_W'(in_word.point_x);
        ry_reg  <= DIFF_W'(in_word.vert0_y) - DIFF_W'(in_word.point_y);
    end

    // Stage 2: six products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg <= d2x_reg * ry_reg;
        p1_reg <= rx_reg * d2y_reg;
        p2_reg <= rx_reg * d1y_reg;
        p3_reg <= d1x_reg * ry_reg;
        p4_reg <= d1x_reg * d2y_reg;
        p5_reg <= d2x_reg * d1y_reg;
    end

    // Stage 3: cross terms, magnitudes, threshold compare
    always_comb
    begin
        cx    = CROSS_W'(p0_reg) - CROSS_W'(p1_reg);
        cy    = CROSS_W'(p2_reg) - CROSS_W'(p3_reg);
        cz    = CROSS_W'(p4_reg) - CROSS_W'(p5_reg);
        czm   = cz[CROSS_W-1] ? MAG_W'(-cz) : MAG_W'(cz);
        area  = {1'b0, czm, 8'd0};
        limit = (MAG_W+9)'(threshold) << (2 * COORD_FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else
        begin
            out_reg.valid      <= s2_valid_reg;
            out_reg.degenerate <= (cz == '0) || (area < limit);
            out_reg.cz_mag     <= czm;
            out_reg.cx_mag     <= cx[CROSS_W-1] ? MAG_W'(-cx) : MAG_W'(cx);
            out_reg.cy_mag     <= cy[CROSS_W-1] ? MAG_W'(-cy) : MAG_W'(cy);
            out_reg.u_neg      <= (cx != '0) && (cx[CROSS_W-1] != cz[CROSS_W-1]);
            out_reg.v_neg      <= (cy != '0) && (cy[CROSS_W-1] != cz[CROSS_W-1]);
        end
    end

    assign out_cross = out_reg;

`ifndef SYNTHESIS
    a_zero_area_degen: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && cz == '0) |=> out_reg.degenerate)
        else $error("zero area not flagged degenerate");
    a_valid_chain: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg)
        else $error("valid lost in front end");
`endif

endmodule

/* rtl/core/tribc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with round.
module tribc_div
    import tribc_pkg::*;
#(
    parameter int NUM_W = 40,
    parameter int DEN_W = 34,
    parameter int Q_W   = 40
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             out_valid,
    output logic [Q_W-1:0]   quot
);

    // Quotient of (num + den/2) / den; only Q_W low bits kept.
    localparam int RW = DEN_W + 1;
    localparam int NW = NUM_W + 1;

    logic             v_reg   [0:Q_W];
    logic [NW-1:0]    n_reg   [0:Q_W];
    logic [DEN_W-1:0] d_reg   [0:Q_W];
    logic [RW-1:0]    r_reg   [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic [NW-1:0]    n_sum;

    // Stage 0: add half divisor
    assign n_sum = NW'(num) + NW'(den >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    // Quotient bits above Q_W are zero because the caller bounds the
    // quotient, so the numerator bits above the low Q_W preload the
    // remainder and the low Q_W bits are shifted in one per stage.
    always_ff @(posedge clk)
    begin
        n_reg[0] <= n_sum << (NW - Q_W);
        d_reg[0] <= den;
        r_reg[0] <= RW'(n_sum >> Q_W);
        q_reg[0] <= '0;
    end

    // One quotient bit per stage, from bit Q_W-1 down
    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_step
            logic [RW:0] trial;
            logic [RW-1:0] rsh;
            always_comb
            begin
                rsh   = {r_reg[k][RW-2:0], n_reg[k][NW-1]};
                trial = {1'b0, rsh} - {2'b0, d_reg[k]};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k+1] <= 1'b0;
                end
                else
                begin
                    v_reg[k+1] <= v_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                n_reg[k+1] <= {n_reg[k][NW-2:0], 1'b0};
                d_reg[k+1] <= d_reg[k];
                r_reg[k+1] <= trial[RW] ? rsh : trial[RW-1:0];
                q_reg[k+1] <= {q_reg[k][Q_W-2:0], ~trial[RW]};
            end
        end
    endgenerate

    assign out_valid = v_reg[Q_W];
    assign quot      = q_reg[Q_W];

endmodule

/* rtl/core/tribc_out.sv */
// Back end: signs, w = 1 - u - v, saturation and output register.
module tribc_out
    import tribc_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS,
    parameter int Q_W = 40
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           degen,
    input  logic           u_neg,
    input  logic           v_neg,
    input  logic [Q_W-1:0] u_mag,
    input  logic [Q_W-1:0] v_mag,
    output logic           out_valid,
    output weight_word_t   out_word
);

    localparam int SW = Q_W + 3;
    localparam logic signed [SW-1:0] ONE  = SW'(1) <<< WEIGHT_FRAC_BITS;
    localparam logic signed [SW-1:0] WMAX = SW'((1 << (WEIGHT_W-1)) - 1);
    localparam logic signed [SW-1:0] WMIN = -SW'(1 << (WEIGHT_W-1));

    function automatic logic signed [WEIGHT_W-1:0] sat(input logic signed [SW-1:0] x);
        if (x > WMAX)
            return WEIGHT_W'(WMAX);
        else if (x < WMIN)
            return WEIGHT_W'(WMIN);
        else
            return WEIGHT_W'(x);
    endfunction

    logic signed [SW-1:0] u_s, v_s, w_s;
    logic                 valid_reg;
    weight_word_t         word_reg;

    // Signed weights
    always_comb
    begin
        u_s = u_neg ? -SW'(u_mag) : SW'(u_mag);
        v_s = v_neg ? -SW'(v_mag) : SW'(v_mag);
        w_s = ONE - u_s - v_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (degen)
        begin
            word_reg.weight_first  <= sat(-ONE);
            word_reg.weight_second <= sat(ONE);
            word_reg.weight_third  <= sat(ONE);
            word_reg.degenerate    <= 1'b1;
        end
        else
        begin
            word_reg.weight_first  <= sat(w_s);
            word_reg.weight_second <= sat(u_s);
            word_reg.weight_third  <= sat(v_s);
            word_reg.degenerate    <= 1'b0;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/core/triangle_barycentric_coords.sv */
// Pipeline of 3 front-end stages + 1 + Q_W divider stages + 1 output stage
// (Q_W = MAG_W + WEIGHT_FRAC_BITS + 1, 51 by default).
// Throughput: one word per cycle; busy is always low, start may be high
// every cycle. Rate is set by the fully pipelined bit-per-stage divider.
// Reset (rst_n low, async) clears all valid bits and sets the threshold to 3.
// The receiver cannot stall; done pulses for one cycle per result word.
module triangle_barycentric_coords
    import tribc_pkg::*;
#(
    parameter int COORD_FRAC_BITS  = DEF_COORD_FRAC_BITS,
    parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tri_word_t           operand,
    output logic                done,
    output weight_word_t        result,
    input  logic                cfg_we,
    input  logic [THRESH_W-1:0] cfg_wdata
);

    // Full quotient width: w is formed from the unsaturated u and v.
    localparam int NUM_W = MAG_W + WEIGHT_FRAC_BITS;
    localparam int Q_W   = NUM_W + 1;

    logic [THRESH_W-1:0] thresh_reg;
    cross_word_t         cr;
    logic                cr_bypass;
    logic                du_valid, dv_valid;
    logic [Q_W-1:0]      u_q, v_q;
    logic [NUM_W-1:0]    u_num, v_num;
    logic [MAG_W-1:0]    den;
    logic                side_v   [0:Q_W+1];
    logic                side_dg  [0:Q_W+1];
    logic                side_un  [0:Q_W+1];
    logic                side_vn  [0:Q_W+1];

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_we)
        begin
            thresh_reg <= cfg_wdata;
        end
    end

    assign busy = 1'b0;

    tribc_cross #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .in_word  (operand),
        .threshold(thresh_reg),
        .out_cross(cr)
    );

    // Degenerate words divide by one to stay safe
    assign cr_bypass = cr.degenerate;
    assign den   = cr_bypass ? MAG_W'(1) : cr.cz_mag;
    assign u_num = {cr.cx_mag, {WEIGHT_FRAC_BITS{1'b0}}};
    assign v_num = {cr.cy_mag, {WEIGHT_FRAC_BITS{1'b0}}};

    tribc_div #(.NUM_W(NUM_W), .DEN_W(MAG_W), .Q_W(Q_W)) u_div_u (
        .clk(clk), .rst_n(rst_n), .in_valid(cr.valid), .num(u_num), .den(den),
        .out_valid(du_valid), .quot(u_q)
    );

    tribc_div #(.NUM_W(NUM_W), .DEN_W(MAG_W), .Q_W(Q_W)) u_div_v (
        .clk(clk), .rst_n(rst_n), .in_valid(cr.valid), .num(v_num), .den(den),
        .out_valid(dv_valid), .quot(v_q)
    );

    // Side band delay matching the divider
    always_comb
    begin
        side_v[0]  = cr.valid;
        side_dg[0] = cr.degenerate;
        side_un[0] = cr.u_neg;
        side_vn[0] = cr.v_neg;
    end

    genvar k;
    generate
        for (k = 0; k <= Q_W; k++)
        begin : g_side
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_v[k+1] <= 1'b0;
                end
                else
                begin
                    side_v[k+1] <= side_v[k];
                end
            end

            always_ff @(posedge clk)
            begin
                side_dg[k+1] <= side_dg[k];
                side_un[k+1] <= side_un[k];
                side_vn[k+1] <= side_vn[k];
            end
        end
    endgenerate

    tribc_out #(.WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS), .Q_W(Q_W)) u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (side_v[Q_W+1]),
        .degen    (side_dg[Q_W+1]),
        .u_neg    (side_un[Q_W+1]),
        .v_neg    (side_vn[Q_W+1]),
        .u_mag    (u_q),
        .v_mag    (v_q),
        .out_valid(done),
        .out_word (result)
    );

`ifndef SYNTHESIS
    a_div_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (du_valid == side_v[Q_W+1]) && (dv_valid == du_valid))
        else $error("divider valid out of step with side band");
    a_degen_word: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |-> (result.weight_second == result.weight_third))
        else $error("degenerate word weights differ");
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the triangle barycentric weight block: directed and random triangles.
`timescale 1ns / 100ps

module tb_top
    import tribc_pkg::*;
();

    localparam int PIPE_LAT = 56;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    tri_word_t           operand = '0;
    logic                done;
    weight_word_t        result;
    logic                cfg_we = 1'b0;
    logic [THRESH_W-1:0] cfg_wdata = '0;

    logic [THRESH_W-1:0] area_thresh = THRESH_RESET;
    tri_word_t           tri_pending[$];
    weight_word_t        weights_due[$];
    int                  err_count = 0;
    int                  idle_pct = 0;
    bit                  hold_send = 1'b0;

    triangle_barycentric_coords uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operand   (operand),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Rounded quotient in Q16, ties away from zero
    function automatic longint div_round(longint num, longint den);
        longint n;
        longint d;
        longint q;
        n = (num < 0 ? -num : num) <<< 16;
        d = den < 0 ? -den : den;
        q = (n + d / 2) / d;
        return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function automatic logic signed [WEIGHT_W-1:0] clamp24(longint v);
        if (v > 64'sd8388607)
            return 24'sh7fffff;
        if (v < -64'sd8388608)
            return 24'sh800000;
        return v[WEIGHT_W-1:0];
    endfunction

    // Expected weights for one triangle word
    function automatic weight_word_t bary_weights(tri_word_t t, logic [THRESH_W-1:0] thr);
        longint d1x, d1y, d2x, d2y, rx, ry, cx, cy, cz, u, v, one, mag;
        weight_word_t w;
        d1x = longint'(t.vert1_x) - longint'(t.vert0_x);
        d1y = longint'(t.vert1_y) - longint'(t.vert0_y);
        d2x = longint'(t.vert2_x) - longint'(t.vert0_x);
        d2y = longint'(t.vert2_y) - longint'(t.vert0_y);
        rx  = longint'(t.vert0_x) - longint'(t.point_x);
        ry  = longint'(t.vert0_y) - longint'(t.point_y);
        cx  = d2x * ry - rx * d2y;
        cy  = rx * d1y - d1x * ry;
        cz  = d1x * d2y - d2x * d1y;
        one = 64'sd65536;
        mag = cz < 0 ? -cz : cz;
        if (cz == 0 || (mag <<< 8) < (longint'(thr) <<< 8))
        begin
            w.weight_first  = clamp24(-one);
            w.weight_second = clamp24(one);
            w.weight_third  = clamp24(one);
            w.degenerate    = 1'b1;
        end
        else
        begin
            u = div_round(cx, cz);
            v = div_round(cy, cz);
            w.weight_first  = clamp24(one - u - v);
            w.weight_second = clamp24(u);
            w.weight_third  = clamp24(v);
            w.degenerate    = 1'b0;
        end
        return w;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Driver: one word per accepted start
    always @(posedge clk)
    begin
        if (rst_n && !(start && busy))
        begin
            if (tri_pending.size() > 0 && !hold_send && $urandom_range(99) >= idle_pct)
            begin
                operand <= tri_pending[0];
                weights_due.push_back(bary_weights(tri_pending[0], area_thresh));
                void'(tri_pending.pop_front());
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare every done word with the oldest expectation
    always @(posedge clk)
    begin
        weight_word_t want;
        if (rst_n && done)
        begin
            if (weights_due.size() == 0)
            begin
                report_mismatch("unexpected word", 0, 0);
            end
            else
            begin
                want = weights_due.pop_front();
                if (result.weight_first !== want.weight_first)
                    report_mismatch("weight_first", result.weight_first, want.weight_first);
                if (result.weight_second !== want.weight_second)
                    report_mismatch("weight_second", result.weight_second, want.weight_second);
                if (result.weight_third !== want.weight_third)
                    report_mismatch("weight_third", result.weight_third, want.weight_third);
                if (result.degenerate !== want.degenerate)
                    report_mismatch("degenerate", result.degenerate, want.degenerate);
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] rnd_coord(int span);
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 16'sh7fff;
        if (r == 1)
            return 16'sh8000;
        if (r < 5)
            return 16'($urandom());
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic tri_word_t rnd_tri();
        tri_word_t t;
        int span;
        span = ($urandom_range(3) == 0) ? 40 : 2000;
        t.vert0_x = rnd_coord(span);
        t.vert0_y = rnd_coord(span);
        t.vert1_x = rnd_coord(span);
        t.vert1_y = rnd_coord(span);
        t.vert2_x = rnd_coord(span);
        t.vert2_y = rnd_coord(span);
        t.point_x = rnd_coord(span);
        t.point_y = rnd_coord(span);
        // collinear triangle now and then
        if ($urandom_range(7) == 0)
        begin
            t.vert2_x = t.vert1_x;
            t.vert2_y = t.vert1_y;
        end
        return t;
    endfunction

    function automatic tri_word_t mk_tri(int x0, int y0, int x1, int y1,
                                         int x2, int y2, int px, int py);
        tri_word_t t;
        t.vert0_x = 16'(x0);
        t.vert0_y = 16'(y0);
        t.vert1_x = 16'(x1);
        t.vert1_y = 16'(y1);
        t.vert2_x = 16'(x2);
        t.vert2_y = 16'(y2);
        t.point_x = 16'(px);
        t.point_y = 16'(py);
        return t;
    endfunction

    // Wait for all results, then let the pipeline drain
    task automatic drain();
        wait (tri_pending.size() == 0 && weights_due.size() == 0);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic set_thresh(logic [THRESH_W-1:0] val);
        drain();
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        area_thresh = val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_random(int n);
        repeat (n) tri_pending.push_back(rnd_tri());
    endtask

    // Stimulus
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct = 27;
        // directed: unit triangle, extremes, tiny and zero area, ties
        tri_pending.push_back(mk_tri(0, 0, 16, 0, 0, 16, 4, 4));
        tri_pending.push_back(mk_tri(0, 0, 16, 0, 0, 16, 0, 0));
        tri_pending.push_back(mk_tri(0, 0, 16, 0, 0, 16, 16, 16));
        tri_pending.push_back(mk_tri(0, 0, 0, 16, 16, 0, 5, 3));
        tri_pending.push_back(mk_tri(0, 0, 1, 0, 0, 1, 0, 0));
        tri_pending.push_back(mk_tri(0, 0, 2, 0, 0, 1, 1, 0));
        tri_pending.push_back(mk_tri(0, 0, 3, 0, 0, 1, 1, 0));
        tri_pending.push_back(mk_tri(0, 0, 3, 0, 0, 1, 2, 0));
        tri_pending.push_back(mk_tri(5, 5, 5, 5, 5, 5, 1, 1));
        tri_pending.push_back(mk_tri(0, 0, 10, 10, 20, 20, 3, 7));
        tri_pending.push_back(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                                     32767, 32767));
        tri_pending.push_back(mk_tri(-32768, -32768, 32767, -32768, -32768, 32767,
                                     -32768, -32768));
        tri_pending.push_back(mk_tri(32767, 32767, -32768, 32767, 32767, -32768,
                                     -32768, -32768));
        tri_pending.push_back(mk_tri(0, 0, 1, 0, 0, 1, 32767, -32768));
        tri_pending.push_back(mk_tri(0, 0, 1, 0, 0, 1, -32768, 32767));
        tri_pending.push_back(mk_tri(-1, -1, -1, -1, -1, -1, -1, -1));
        tri_pending.push_back(mk_tri(0, 0, 32767, 0, 0, 32767, 1, 1));
        load_random(130);

        set_thresh(16'd0);
        tri_pending.push_back(mk_tri(0, 0, 1, 0, 0, 1, 0, 0));
        tri_pending.push_back(mk_tri(5, 5, 5, 5, 5, 5, 1, 1));
        load_random(100);

        // sender holds off until everything is back
        wait (tri_pending.size() < 60);
        hold_send = 1'b1;
        wait (weights_due.size() == 0);
        repeat (4) @(posedge clk);
        hold_send = 1'b0;

        set_thresh(16'd65535);
        idle_pct = 52;
        tri_pending.push_back(mk_tri(0, 0, 4096, 0, 0, 4096, 100, 100));
        tri_pending.push_back(mk_tri(0, 0, 4095, 0, 0, 4096, 100, 100));
        load_random(100);

        set_thresh(16'd1000);
        load_random(100);

        set_thresh(16'($urandom()));
        idle_pct = 0;
        load_random(100);

        drain();
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit
    initial
    begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

/* files.f */
rtl/core/tribc_pkg.sv
rtl/core/tribc_cross.sv
rtl/core/tribc_div.sv
rtl/core/tribc_out.sv
rtl/core/triangle_barycentric_coords.sv
tb/sv/tb_top.sv
